### rtl/scope_peak_decimate_edge_trigger_assert.svh
// assertion macros shared by the scope front end modules
// depends on nothing; included by the modules that check their own logic
`ifndef SCOPE_PEAK_DECIMATE_EDGE_TRIGGER_ASSERT_SVH
`define SCOPE_PEAK_DECIMATE_EDGE_TRIGGER_ASSERT_SVH

// same-cycle implication, held off during reset
`define SPDET_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("spdet assertion failed");

// next-cycle implication, held off during reset
`define SPDET_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("spdet assertion failed");

`endif

### rtl/spdet_pkg.sv
// shared types, constants and codes of the scope peak-detect front end
// depends on nothing; used by every other file but the assertion header through scoped names
package spdet_pkg;

	localparam int RING_DEPTH   = 1024;
	localparam int IDX_BITS     = $clog2(RING_DEPTH);
	localparam int SAMPLE_BITS  = 16;
	localparam int OUT_IDX_BITS = 10;
	localparam int SPP_BITS     = 11;
	localparam int WIN_BITS     = 11;
	localparam int PRE_BITS     = 10;
	localparam int MODE_BITS    = 2;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [MODE_BITS-1:0] mode_t;

	// full scale of a two's complement sample
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPP     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRETRIG = 3'd4;

	// trigger modes; the fourth code is rejected on write
	localparam mode_t TRIG_NONE    = 2'd0;
	localparam mode_t TRIG_RISE    = 2'd1;
	localparam mode_t TRIG_FALL    = 2'd2;
	localparam mode_t TRIG_INVALID = 2'd3;

	// item actions and result kinds
	localparam logic ACT_SAMPLE   = 1'b0;
	localparam logic ACT_TRIGGER  = 1'b1;
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_TRIGGER = 1'b1;

	// search request from the top level to the sequencer
	typedef struct packed {
		idx_t    start;
		mode_t   mode;
		sample_t level;
	} search_req_t;

	// search answer
	typedef struct packed {
		idx_t idx;
		logic found;
	} search_rsp_t;

	// registered read of the ring stores, unwritten entries already zeroed
	typedef struct packed {
		sample_t min_prev;
		sample_t max_pos;
	} store_rd_t;

endpackage

### rtl/spdet_if.sv
// valid/ready channels carrying input items and result items
// depends on spdet_pkg
interface spdet_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   action;
	logic signed [spdet_pkg::SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output action, output sample_value, input ready);
	modport sink (input valid, input action, input sample_value, output ready);
endinterface

interface spdet_result_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      result_kind;
	logic signed [spdet_pkg::SAMPLE_BITS-1:0]  pixel_min;
	logic signed [spdet_pkg::SAMPLE_BITS-1:0]  pixel_max;
	logic [spdet_pkg::OUT_IDX_BITS-1:0]        trigger_index;
	logic [spdet_pkg::OUT_IDX_BITS-1:0]        display_start;
	logic                                      trigger_found;

	modport source (output valid, output result_kind, output pixel_min, output pixel_max,
		output trigger_index, output display_start, output trigger_found, input ready);
	modport sink (input valid, input result_kind, input pixel_min, input pixel_max,
		input trigger_index, input display_start, input trigger_found, output ready);
endinterface

### rtl/spdet_store.sv
// min/max ring stores with write pointer and fill tracking
// depends on spdet_pkg
module spdet_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  spdet_pkg::sample_t    wr_min,
	input  spdet_pkg::sample_t    wr_max,
	input  logic                  rd_en,
	input  spdet_pkg::idx_t       rd_pos,
	output spdet_pkg::idx_t       wr_ptr,
	output spdet_pkg::store_rd_t  rd
);

	spdet_pkg::sample_t min_mem [spdet_pkg::RING_DEPTH];
	spdet_pkg::sample_t max_mem [spdet_pkg::RING_DEPTH];

	spdet_pkg::idx_t    wr_ptr_q;
	logic               wrapped_q;
	spdet_pkg::sample_t min_rd_q;
	spdet_pkg::sample_t max_rd_q;
	logic               prev_ok_q;
	logic               pos_ok_q;
	spdet_pkg::idx_t    rd_prev;

	assign rd_prev = rd_pos - spdet_pkg::idx_t'(1);

	// pointer advances once per stored pixel; wrapped marks every entry written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			wrapped_q <= 1'b0;
		end else if (wr_en) begin
			wr_ptr_q <= wr_ptr_q + spdet_pkg::idx_t'(1);
			if (wr_ptr_q == spdet_pkg::idx_t'(spdet_pkg::RING_DEPTH - 1)) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			min_mem[wr_ptr_q] <= wr_min;
			max_mem[wr_ptr_q] <= wr_max;
		end
	end

	// registered read: min at the previous entry, max at the current one
	always_ff @(posedge clk) begin
		if (rd_en) begin
			min_rd_q  <= min_mem[rd_prev];
			max_rd_q  <= max_mem[rd_pos];
			prev_ok_q <= wrapped_q || (rd_prev < wr_ptr_q);
			pos_ok_q  <= wrapped_q || (rd_pos < wr_ptr_q);
		end
	end

	// entries never written read as zero
	assign rd.min_prev = prev_ok_q ? min_rd_q : '0;
	assign rd.max_pos  = pos_ok_q ? max_rd_q : '0;
	assign wr_ptr      = wr_ptr_q;

endmodule

### rtl/spdet_search.sv
// backward edge search sequencer with one shared level comparator
// depends on spdet_pkg, spdet_store read data and the assertion header
`include "scope_peak_decimate_edge_trigger_assert.svh"

module spdet_search (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  spdet_pkg::search_req_t  req,
	output logic                    busy,
	output logic                    rd_en,
	output spdet_pkg::idx_t         rd_pos,
	input  spdet_pkg::store_rd_t    rd,
	output logic                    rsp_valid,
	output spdet_pkg::search_rsp_t  rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_CMP  = 3'b100
	} state_t;

	state_t                 state_q;
	spdet_pkg::idx_t        pos_q;
	spdet_pkg::idx_t        cnt_q;
	spdet_pkg::idx_t        start_q;
	spdet_pkg::mode_t       mode_q;
	spdet_pkg::sample_t     level_q;
	logic                   rsp_valid_q;
	spdet_pkg::search_rsp_t rsp_q;
	logic                   hit;
	logic                   last_step;

	// shared comparator: crossing test between two neighboring pixels
	always_comb begin
		hit = 1'b0;
		unique case (mode_q)
			spdet_pkg::TRIG_RISE: hit = ($signed(rd.min_prev) <= $signed(level_q))
				&& ($signed(rd.max_pos) > $signed(level_q));
			spdet_pkg::TRIG_FALL: hit = ($signed(rd.min_prev) > $signed(level_q))
				&& ($signed(rd.max_pos) <= $signed(level_q));
			default: hit = 1'b0;
		endcase
	end

	assign last_step = (cnt_q == spdet_pkg::idx_t'(spdet_pkg::RING_DEPTH - 1));

	// sequencer: read one entry pair, compare, step back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.mode == spdet_pkg::TRIG_RISE || req.mode == spdet_pkg::TRIG_FALL) begin
							state_q <= S_READ;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit || last_step) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// search position, step count and answer
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			pos_q     <= req.start;
			start_q   <= req.start;
			mode_q    <= req.mode;
			level_q   <= req.level;
			cnt_q     <= '0;
			rsp_q.idx   <= req.start;
			rsp_q.found <= 1'b0;
		end else if (state_q == S_CMP) begin
			if (hit) begin
				rsp_q.idx   <= pos_q;
				rsp_q.found <= 1'b1;
			end else if (last_step) begin
				rsp_q.idx   <= start_q;
				rsp_q.found <= 1'b0;
			end else begin
				pos_q <= pos_q - spdet_pkg::idx_t'(1);
				cnt_q <= cnt_q + spdet_pkg::idx_t'(1);
			end
		end
	end

	assign rd_en     = (state_q == S_READ);
	assign rd_pos    = pos_q;
	assign busy      = (state_q != S_IDLE) || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`SPDET_ASSERT_IMP(a_req_when_idle, clk, arst_n, req_valid, state_q == S_IDLE && !rsp_valid_q)
	`SPDET_ASSERT_IMP(a_found_needs_mode, clk, arst_n, rsp_valid_q && rsp_q.found, mode_q == spdet_pkg::TRIG_RISE || mode_q == spdet_pkg::TRIG_FALL)
	`SPDET_ASSERT_NEXT(a_read_then_cmp, clk, arst_n, state_q == S_READ, state_q == S_CMP)

endmodule

### rtl/scope_peak_decimate_edge_trigger.sv
// One-channel scope front end: peak-detect decimation into a 1024-entry min/max
// ring and a backward edge-trigger search over it. Every samples_per_pixel accepted
// samples a min/max pair is stored and sent out. A trigger beat occupies the block
// while the search steps back, reading then comparing each entry, over at most all
// 1024 entries: the stores have one read port each and a single comparator tests
// one entry pair per read. With trigger mode none the answer comes without a search.
// Entries not yet written since reset read as zero through fill tracking, so there
// is no clearing pass after reset.
// Depends on spdet_pkg, spdet_if, spdet_store, spdet_search and the assertion header.
`include "scope_peak_decimate_edge_trigger_assert.svh"

module scope_peak_decimate_edge_trigger (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [spdet_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [spdet_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	spdet_item_if.sink                             item,
	spdet_result_if.source                         result
);

	logic [spdet_pkg::SPP_BITS-1:0] spp_q;
	spdet_pkg::mode_t               mode_q;
	spdet_pkg::sample_t             level_q;
	logic [spdet_pkg::WIN_BITS-1:0] window_q;
	logic [spdet_pkg::PRE_BITS-1:0] pretrig_q;

	logic [spdet_pkg::SPP_BITS-1:0] samples_left_q;
	spdet_pkg::sample_t             run_min_q;
	spdet_pkg::sample_t             run_max_q;

	logic                                 out_v_q;
	logic                                 kind_q;
	spdet_pkg::sample_t                   pmin_q;
	spdet_pkg::sample_t                   pmax_q;
	logic [spdet_pkg::OUT_IDX_BITS-1:0]   tidx_q;
	logic [spdet_pkg::OUT_IDX_BITS-1:0]   dstart_q;
	logic                                 tfound_q;

	logic                   accept;
	logic                   sample_acc;
	logic                   trig_acc;
	logic                   pixel_done;
	spdet_pkg::sample_t     new_min;
	spdet_pkg::sample_t     new_max;
	spdet_pkg::idx_t        wr_ptr;
	spdet_pkg::search_req_t req;
	logic                   search_busy;
	logic                   rd_en;
	spdet_pkg::idx_t        rd_pos;
	spdet_pkg::store_rd_t   rd;
	logic                   rsp_valid;
	spdet_pkg::search_rsp_t rsp;
	logic                   out_free;
	spdet_pkg::idx_t        disp_idx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q     <= spdet_pkg::SPP_BITS'(4);
			mode_q    <= spdet_pkg::TRIG_RISE;
			level_q   <= '0;
			window_q  <= spdet_pkg::WIN_BITS'(512);
			pretrig_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spdet_pkg::CFG_SPP:     spp_q <= cfg_data[spdet_pkg::SPP_BITS-1:0];
				spdet_pkg::CFG_MODE: begin
					if (cfg_data[spdet_pkg::MODE_BITS-1:0] != spdet_pkg::TRIG_INVALID) begin
						mode_q <= cfg_data[spdet_pkg::MODE_BITS-1:0];
					end
				end
				spdet_pkg::CFG_LEVEL:   level_q <= cfg_data[spdet_pkg::SAMPLE_BITS-1:0];
				spdet_pkg::CFG_WINDOW:  window_q <= cfg_data[spdet_pkg::WIN_BITS-1:0];
				spdet_pkg::CFG_PRETRIG: pretrig_q <= cfg_data[spdet_pkg::PRE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input handshake: one item at a time, output slot free or draining
	assign out_free   = !out_v_q || result.ready;
	assign item.ready = !search_busy && out_free;
	assign accept     = item.valid && item.ready;
	assign sample_acc = accept && (item.action == spdet_pkg::ACT_SAMPLE);
	assign trig_acc   = accept && (item.action == spdet_pkg::ACT_TRIGGER);

	// running peak detect
	assign new_min    = ($signed(item.sample_value) < $signed(run_min_q)) ? item.sample_value : run_min_q;
	assign new_max    = ($signed(item.sample_value) > $signed(run_max_q)) ? item.sample_value : run_max_q;
	assign pixel_done = (samples_left_q <= spdet_pkg::SPP_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= spdet_pkg::SPP_BITS'(4);
			run_min_q      <= spdet_pkg::SAMPLE_MAX;
			run_max_q      <= spdet_pkg::SAMPLE_MIN;
		end else if (sample_acc) begin
			if (pixel_done) begin
				samples_left_q <= (spp_q == '0) ? spdet_pkg::SPP_BITS'(1) : spp_q;
				run_min_q      <= spdet_pkg::SAMPLE_MAX;
				run_max_q      <= spdet_pkg::SAMPLE_MIN;
			end else begin
				samples_left_q <= samples_left_q - spdet_pkg::SPP_BITS'(1);
				run_min_q      <= new_min;
				run_max_q      <= new_max;
			end
		end
	end

	// search request: start window_width entries behind the write pointer
	assign req.start = wr_ptr - window_q[spdet_pkg::IDX_BITS-1:0];
	assign req.mode  = mode_q;
	assign req.level = level_q;

	spdet_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (sample_acc && pixel_done),
		.wr_min (new_min),
		.wr_max (new_max),
		.rd_en  (rd_en),
		.rd_pos (rd_pos),
		.wr_ptr (wr_ptr),
		.rd     (rd)
	);

	spdet_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (trig_acc),
		.req       (req),
		.busy      (search_busy),
		.rd_en     (rd_en),
		.rd_pos    (rd_pos),
		.rd        (rd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	assign disp_idx = rsp.idx - pretrig_q[spdet_pkg::IDX_BITS-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((sample_acc && pixel_done) || rsp_valid) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc && pixel_done) begin
			kind_q   <= spdet_pkg::KIND_PIXEL;
			pmin_q   <= new_min;
			pmax_q   <= new_max;
			tidx_q   <= '0;
			dstart_q <= '0;
			tfound_q <= 1'b0;
		end else if (rsp_valid) begin
			kind_q   <= spdet_pkg::KIND_TRIGGER;
			pmin_q   <= '0;
			pmax_q   <= '0;
			tidx_q   <= spdet_pkg::OUT_IDX_BITS'(rsp.idx);
			dstart_q <= spdet_pkg::OUT_IDX_BITS'(disp_idx);
			tfound_q <= rsp.found;
		end
	end

	assign result.valid         = out_v_q;
	assign result.result_kind   = kind_q;
	assign result.pixel_min     = pmin_q;
	assign result.pixel_max     = pmax_q;
	assign result.trigger_index = tidx_q;
	assign result.display_start = dstart_q;
	assign result.trigger_found = tfound_q;

	// checks
	`SPDET_ASSERT_IMP(a_busy_blocks_input, clk, arst_n, search_busy, !item.ready)
	`SPDET_ASSERT_NEXT(a_pixel_emitted, clk, arst_n, sample_acc && pixel_done, result.valid && result.result_kind == spdet_pkg::KIND_PIXEL)
	`SPDET_ASSERT_IMP(a_pixel_ordered, clk, arst_n, result.valid && result.result_kind == spdet_pkg::KIND_PIXEL, $signed(result.pixel_min) <= $signed(result.pixel_max))

endmodule
